[sv/npsv_pkg.sv]
// Package for the note phase accumulator sine voice.
// Holds the default sizes, register indexes, datapath operation codes and constant tables.
// Used by npsv_ctrl, npsv_dp and the top level.
package npsv_pkg;

	localparam int PHASE_BITS_DEF  = 32;
	localparam int SINE_DEPTH_DEF  = 1024;
	localparam int SAMPLE_BITS_DEF = 16;

	localparam logic [31:0] SAMPLE_PERIOD_RST = 32'd89478;
	localparam logic [15:0] PITCH_BEND_RST    = 16'd16384;

	localparam logic REG_SAMPLE_PERIOD = 1'b0;
	localparam logic REG_PITCH_BEND    = 1'b1;

	localparam logic REQ_NOTE_ON = 1'b1;

	localparam logic [7:0]  PC_COUNT         = 8'd12;
	localparam logic [7:0]  NOTE_BASE_OFS    = 8'd4;
	localparam logic [3:0]  TOP_OCTAVE_SHIFT = 4'd10;
	localparam logic [2:0]  HORNER_LAST      = 3'd4;
	localparam logic [2:0]  COEF_TOP         = 3'd5;
	localparam logic [30:0] Q30_ONE          = 31'h4000_0000;
	localparam logic [6:0]  SCALE_DIV        = 7'd127;
	localparam logic [31:0] RECIP_127        = 32'd33818640;
	localparam logic [63:0] ROUND_BIAS       = 64'd136365211648;

	localparam int OP_W = 5;
	localparam logic [OP_W-1:0] OP_IDLE      = 5'd0;
	localparam logic [OP_W-1:0] OP_NOTE_LOAD = 5'd1;
	localparam logic [OP_W-1:0] OP_NOTE_RED  = 5'd2;
	localparam logic [OP_W-1:0] OP_NOTE_FREQ = 5'd3;
	localparam logic [OP_W-1:0] OP_TICK      = 5'd4;
	localparam logic [OP_W-1:0] OP_TICK_CHK  = 5'd5;
	localparam logic [OP_W-1:0] OP_MUL_FB    = 5'd6;
	localparam logic [OP_W-1:0] OP_MUL_P0    = 5'd7;
	localparam logic [OP_W-1:0] OP_MUL_P1    = 5'd8;
	localparam logic [OP_W-1:0] OP_SUM_P1    = 5'd9;
	localparam logic [OP_W-1:0] OP_PHASE     = 5'd10;
	localparam logic [OP_W-1:0] OP_MUL_TT    = 5'd11;
	localparam logic [OP_W-1:0] OP_T2        = 5'd12;
	localparam logic [OP_W-1:0] OP_HORN_MUL  = 5'd13;
	localparam logic [OP_W-1:0] OP_HORN_ADD  = 5'd14;
	localparam logic [OP_W-1:0] OP_FIN_MUL   = 5'd15;
	localparam logic [OP_W-1:0] OP_FIN_CLAMP = 5'd16;
	localparam logic [OP_W-1:0] OP_MUL_VF    = 5'd17;
	localparam logic [OP_W-1:0] OP_MUL_MAG   = 5'd18;
	localparam logic [OP_W-1:0] OP_ROUND     = 5'd19;
	localparam logic [OP_W-1:0] OP_MUL_RECIP = 5'd20;
	localparam logic [OP_W-1:0] OP_QUOT      = 5'd21;
	localparam logic [OP_W-1:0] OP_OUT       = 5'd22;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic [2:0]      coef_k;
	} npsv_cmd_t;

	typedef struct packed {
		logic started;
		logic pc_ge12;
	} npsv_stat_t;

	// Top octave (notes 116 to 127) as round(f * 2^16), by pitch class.
	function automatic logic [29:0] top_octave(input logic [3:0] idx);
		logic [29:0] v;
		case (idx)
			4'd0: v = 30'd435478539;
			4'd1: v = 30'd461373440;
			4'd2: v = 30'd488808132;
			4'd3: v = 30'd517874176;
			4'd4: v = 30'd548668578;
			4'd5: v = 30'd581294109;
			4'd6: v = 30'd615859655;
			4'd7: v = 30'd652480576;
			4'd8: v = 30'd691279090;
			4'd9: v = 30'd732384684;
			4'd10: v = 30'd775934544;
			4'd11: v = 30'd822074013;
			default: v = '0;
		endcase
		return v;
	endfunction

	// Odd Taylor coefficients of the sine in Q2.30, lowest order first.
	function automatic logic signed [31:0] sine_coef(input logic [2:0] k);
		logic signed [31:0] c;
		case (k)
			3'd0: c = 32'sd1686629713;
			3'd1: c = -32'sd693598668;
			3'd2: c = 32'sd85569306;
			3'd3: c = -32'sd5026995;
			3'd4: c = 32'sd172272;
			3'd5: c = -32'sd3864;
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

[sv/npsv_ctrl.sv]
// Controller state machine of the sine voice.
// Sequences the datapath operations for note-on and tick transactions and owns the output valid.
// Depends on npsv_pkg.
module npsv_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic                   s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output npsv_pkg::npsv_cmd_t    cmd,
	input  npsv_pkg::npsv_stat_t   stat
);
	import npsv_pkg::*;

	logic [OP_W-1:0] state_q, state_d;
	logic [2:0]      k_q;
	logic            out_valid_q;
	logic            out_free;

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == OP_IDLE);
	assign m_tvalid = out_valid_q;

	always_comb begin
		state_d    = state_q;
		cmd.op     = state_q;
		cmd.coef_k = k_q;
		case (state_q)
			OP_IDLE: begin
				if (s_tvalid) begin
					if (s_tuser == REQ_NOTE_ON) begin
						cmd.op  = OP_NOTE_LOAD;
						state_d = OP_NOTE_RED;
					end else begin
						cmd.op  = OP_TICK;
						state_d = OP_TICK_CHK;
					end
				end
			end
			OP_NOTE_RED: begin
				if (!stat.pc_ge12) begin
					state_d = OP_NOTE_FREQ;
				end
			end
			OP_NOTE_FREQ: state_d = OP_IDLE;
			OP_TICK_CHK:  state_d = stat.started ? OP_MUL_FB : OP_OUT;
			OP_MUL_FB:    state_d = OP_MUL_P0;
			OP_MUL_P0:    state_d = OP_MUL_P1;
			OP_MUL_P1:    state_d = OP_SUM_P1;
			OP_SUM_P1:    state_d = OP_PHASE;
			OP_PHASE:     state_d = OP_MUL_TT;
			OP_MUL_TT:    state_d = OP_T2;
			OP_T2:        state_d = OP_HORN_MUL;
			OP_HORN_MUL:  state_d = OP_HORN_ADD;
			OP_HORN_ADD:  state_d = (k_q == 3'd0) ? OP_FIN_MUL : OP_HORN_MUL;
			OP_FIN_MUL:   state_d = OP_FIN_CLAMP;
			OP_FIN_CLAMP: state_d = OP_MUL_VF;
			OP_MUL_VF:    state_d = OP_MUL_MAG;
			OP_MUL_MAG:   state_d = OP_ROUND;
			OP_ROUND:     state_d = OP_MUL_RECIP;
			OP_MUL_RECIP: state_d = OP_QUOT;
			OP_QUOT:      state_d = OP_OUT;
			OP_OUT: begin
				if (out_free) begin
					state_d = OP_IDLE;
				end else begin
					cmd.op = OP_IDLE;
				end
			end
			default: state_d = OP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= OP_IDLE;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == OP_T2) begin
				k_q <= HORNER_LAST;
			end else if (state_q == OP_HORN_ADD && k_q != 3'd0) begin
				k_q <= k_q - 3'd1;
			end
			if (cmd.op == OP_OUT) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef ASSERT_OFF
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q != OP_IDLE))
		else $error("Accepted transaction did not start work.");
	a_horner_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == OP_HORN_ADD) |-> (k_q <= HORNER_LAST))
		else $error("Polynomial step counter out of range.");
	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_OUT) |=> (m_tvalid && state_q == OP_IDLE))
		else $error("Result load did not raise the output valid.");
`endif

endmodule

[sv/npsv_dp.sv]
// Datapath of the sine voice: configuration and voice registers, one shared 32x32 multiplier,
// the phase accumulator, the sine polynomial and the velocity scaling.
// Depends on npsv_pkg; driven by npsv_ctrl commands.
module npsv_dp #(
	parameter int PHASE_BITS       = npsv_pkg::PHASE_BITS_DEF,
	parameter int SINE_TABLE_DEPTH = npsv_pkg::SINE_DEPTH_DEF,
	parameter int SAMPLE_BITS      = npsv_pkg::SAMPLE_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	input  logic                     cfg_index,
	input  logic [31:0]              cfg_data,
	input  logic [6:0]               note_code,
	input  logic [6:0]               strike_level,
	input  logic [15:0]              start_delay,
	input  npsv_pkg::npsv_cmd_t      cmd,
	output npsv_pkg::npsv_stat_t     stat,
	output logic [SAMPLE_BITS-1:0]   sample,
	output logic                     sounding
);
	import npsv_pkg::*;

	localparam int LOG2D    = $clog2(SINE_TABLE_DEPTH);
	localparam int STEP_LSB = 62 - PHASE_BITS;
	localparam int Y_W      = SAMPLE_BITS + 6;
	localparam int QW       = SAMPLE_BITS - 1;
	localparam logic [31:0] FULL_SCALE = 32'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
	localparam logic [QW-1:0] QUOT_MAX = QW'(64'd1 << (SAMPLE_BITS - 2));

	logic [31:0]             sp_q;
	logic [15:0]             bend_q;
	logic [6:0]              vel_q;
	logic [29:0]             freq_q;
	logic [PHASE_BITS-1:0]   phase_q;
	logic signed [17:0]      ticks_q;
	logic [7:0]              pc_q;
	logic [3:0]              oct_q;
	logic [63:0]             prod_q;
	logic [63:0]             mul_p;
	logic [31:0]             mul_a, mul_b;
	logic [13:0]             fbhi_q;
	logic [77:0]             step_q;
	logic [30:0]             t_q, t2_q, t_c, acc_mag_q, mag_q, r_q30;
	logic [1:0]              quad_q, quad_c;
	logic                    acc_neg_q;
	logic [31:0]             p_c;
	logic [Y_W-1:0]          y_q, rem_c;
	logic [QW-1:0]           q0_c, quot_q, quot_c;
	logic signed [32:0]      horn_sum_c;
	logic signed [31:0]      coef_c, coef_top;
	logic [29:0]             oct_v_c, freq_c;
	logic [30:0]             oct_w_c;
	logic [3:0]              shift_c;
	logic [63:0]             round_c;
	logic [SAMPLE_BITS-1:0]  sample_q;
	logic                    sounding_q;
	logic                    started;

	assign started      = (ticks_q == 18'sd2);
	assign stat.started = started;
	assign stat.pc_ge12 = (pc_q >= PC_COUNT);
	assign sample       = sample_q;
	assign sounding     = sounding_q;

	always_comb begin
		p_c      = {phase_q[PHASE_BITS-1 -: LOG2D], {(32 - LOG2D){1'b0}}};
		quad_c   = p_c[31:30];
		t_c      = quad_c[0] ? (Q30_ONE - {1'b0, p_c[29:0]}) : {1'b0, p_c[29:0]};
		r_q30    = prod_q[60:30];
		coef_c   = sine_coef(cmd.coef_k);
		coef_top = sine_coef(COEF_TOP);
		horn_sum_c = 33'(coef_c) + (acc_neg_q ? -$signed({2'b00, r_q30})
			: $signed({2'b00, r_q30}));
		oct_v_c  = top_octave(pc_q[3:0]);
		shift_c  = TOP_OCTAVE_SHIFT - oct_q;
		oct_w_c  = {oct_v_c, 1'b0} >> shift_c;
		freq_c   = (shift_c == 4'd0) ? oct_v_c : 30'((oct_w_c + 31'd1) >> 1);
		round_c  = prod_q + ROUND_BIAS;
		q0_c     = prod_q[32 +: QW];
		rem_c    = y_q - ({q0_c, 7'd0} - Y_W'(q0_c));
		quot_c   = (rem_c >= Y_W'(SCALE_DIV)) ? (q0_c + 1'b1) : q0_c;
	end

	always_comb begin
		case (cmd.op)
			OP_MUL_FB: begin
				mul_a = {2'b00, freq_q};
				mul_b = {16'd0, bend_q};
			end
			OP_MUL_P0: begin
				mul_a = prod_q[31:0];
				mul_b = sp_q;
			end
			OP_MUL_P1: begin
				mul_a = {18'd0, fbhi_q};
				mul_b = sp_q;
			end
			OP_MUL_TT: begin
				mul_a = {1'b0, t_c};
				mul_b = {1'b0, t_c};
			end
			OP_HORN_MUL: begin
				mul_a = {1'b0, acc_mag_q};
				mul_b = {1'b0, t2_q};
			end
			OP_FIN_MUL: begin
				mul_a = {1'b0, acc_mag_q};
				mul_b = {1'b0, t_q};
			end
			OP_MUL_VF: begin
				mul_a = {25'd0, vel_q};
				mul_b = FULL_SCALE;
			end
			OP_MUL_MAG: begin
				mul_a = {1'b0, mag_q};
				mul_b = prod_q[31:0];
			end
			OP_MUL_RECIP: begin
				mul_a = 32'(y_q);
				mul_b = RECIP_127;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q    <= SAMPLE_PERIOD_RST;
			bend_q  <= PITCH_BEND_RST;
			vel_q   <= '0;
			freq_q  <= '0;
			phase_q <= '0;
			ticks_q <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_SAMPLE_PERIOD: sp_q <= cfg_data;
					REG_PITCH_BEND:    bend_q <= cfg_data[15:0];
					default: ;
				endcase
			end
			case (cmd.op)
				OP_NOTE_LOAD: begin
					vel_q   <= strike_level;
					phase_q <= '0;
					ticks_q <= -$signed({2'b00, start_delay});
				end
				OP_NOTE_FREQ: freq_q <= freq_c;
				OP_TICK: begin
					if (ticks_q < 18'sd2) begin
						ticks_q <= ticks_q + 18'sd1;
					end
				end
				OP_PHASE: phase_q <= phase_q + step_q[STEP_LSB +: PHASE_BITS];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_NOTE_LOAD: begin
				pc_q  <= {1'b0, note_code} + NOTE_BASE_OFS;
				oct_q <= '0;
			end
			OP_NOTE_RED: begin
				if (pc_q >= PC_COUNT) begin
					pc_q  <= pc_q - PC_COUNT;
					oct_q <= oct_q + 4'd1;
				end
			end
			OP_MUL_FB: prod_q <= mul_p;
			OP_MUL_P0: begin
				fbhi_q <= prod_q[45:32];
				prod_q <= mul_p;
			end
			OP_MUL_P1: begin
				step_q <= 78'(prod_q);
				prod_q <= mul_p;
			end
			OP_SUM_P1: step_q <= step_q + {prod_q[45:0], 32'd0};
			OP_MUL_TT: begin
				t_q    <= t_c;
				quad_q <= quad_c;
				prod_q <= mul_p;
			end
			OP_T2: begin
				t2_q      <= r_q30;
				acc_neg_q <= coef_top[31];
				acc_mag_q <= coef_top[31] ? 31'(-coef_top) : coef_top[30:0];
			end
			OP_HORN_MUL: prod_q <= mul_p;
			OP_HORN_ADD: begin
				acc_neg_q <= horn_sum_c[32];
				acc_mag_q <= horn_sum_c[32] ? 31'(-horn_sum_c) : horn_sum_c[30:0];
			end
			OP_FIN_MUL: prod_q <= mul_p;
			OP_FIN_CLAMP: begin
				if (acc_neg_q) begin
					mag_q <= '0;
				end else if (r_q30 > Q30_ONE) begin
					mag_q <= Q30_ONE;
				end else begin
					mag_q <= r_q30;
				end
			end
			OP_MUL_VF:    prod_q <= mul_p;
			OP_MUL_MAG:   prod_q <= mul_p;
			OP_ROUND:     y_q <= round_c[31 +: Y_W];
			OP_MUL_RECIP: prod_q <= mul_p;
			OP_QUOT:      quot_q <= quot_c;
			OP_OUT: begin
				sounding_q <= started;
				if (started) begin
					sample_q <= quad_q[1] ? -SAMPLE_BITS'(quot_q) : SAMPLE_BITS'(quot_q);
				end else begin
					sample_q <= '0;
				end
			end
			default: ;
		endcase
	end

`ifndef ASSERT_OFF
	a_ticks_saturate: assert property (@(posedge clk) disable iff (!arst_n)
		ticks_q <= 18'sd2)
		else $error("Start counter passed its saturation value.");
	a_mag_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_MUL_VF) |-> (mag_q <= Q30_ONE))
		else $error("Sine magnitude above one.");
	a_note_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_NOTE_FREQ) |-> (pc_q < PC_COUNT && oct_q <= TOP_OCTAVE_SHIFT))
		else $error("Note reduction left an invalid pitch class or octave.");
	a_quot_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_OUT && started) |-> (quot_q <= QUOT_MAX))
		else $error("Scaled sample above half scale.");
`endif

endmodule

[sv/note_phase_accumulator_sine_voice.sv]
// Sine voice: m_tvalid rises once a sounding tick has run the phase step, the sine polynomial
// and the scaling, or once a silent tick has passed the start check; the next transaction can
// be accepted once the result is loaded. A note-on runs one octave reduction step per octave.
// One transaction is in work at a time; the pace is set by the single shared 32x32 multiplier
// that runs the phase step, the sine polynomial and the scaling in turn.
// Reset is asynchronous and active low; it clears the voice state and loads the register
// defaults. A finished result waits in the output register while the next transaction is taken.
module note_phase_accumulator_sine_voice #(
	parameter int PHASE_BITS       = npsv_pkg::PHASE_BITS_DEF,
	parameter int SINE_TABLE_DEPTH = npsv_pkg::SINE_DEPTH_DEF,
	parameter int SAMPLE_BITS      = npsv_pkg::SAMPLE_BITS_DEF,
	localparam int OUT_TDATA_W     = ((SAMPLE_BITS + 7) / 8) * 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [31:0]             s_tdata,   // note_code, strike_level, start_delay, zero pad
	input  logic                    s_tuser,   // req_type
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [OUT_TDATA_W-1:0]  m_tdata,   // sample, zero pad
	output logic                    m_tuser,   // sounding
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic                    cfg_index,
	input  logic [31:0]             cfg_data
);
	import npsv_pkg::*;

	npsv_cmd_t               cmd;
	npsv_stat_t              stat;
	logic [SAMPLE_BITS-1:0]  sample;

	assign cfg_ready = 1'b1;
	assign m_tdata   = OUT_TDATA_W'(sample);

	npsv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.stat     (stat)
	);

	npsv_dp #(
		.PHASE_BITS       (PHASE_BITS),
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
		.SAMPLE_BITS      (SAMPLE_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.note_code    (s_tdata[6:0]),
		.strike_level (s_tdata[13:7]),
		.start_delay  (s_tdata[29:14]),
		.cmd          (cmd),
		.stat         (stat),
		.sample       (sample),
		.sounding     (m_tuser)
	);

endmodule

[dv/note_phase_accumulator_sine_voice_tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for note_phase_accumulator_sine_voice: note-on and tick transactions
// go in on the stream port; samples are checked field by field against a voice model kept here
// or the expected values of typed table rows. Depends on npsv_pkg and the voice RTL only.
module note_phase_accumulator_sine_voice_tb;
	import npsv_pkg::*;

	localparam logic REQ_TICK  = 1'b0;
	localparam int   N_ITEMS   = 1100;
	localparam int   N_PHASES  = 6;
	localparam int   SETTLE    = 40;
	localparam int   PRINT_MAX = 30;

	typedef struct packed {
		logic        kind;
		logic [6:0]  note;
		logic [6:0]  level;
		logic [15:0] delay;
	} voice_req_t;

	typedef struct packed {
		logic signed [15:0] sample;
		logic               sounding;
	} voice_out_t;

	typedef struct packed {
		voice_req_t req;
		logic       typed;
		voice_out_t want;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        s_tuser = REQ_TICK;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = REG_SAMPLE_PERIOD;
	logic [31:0] cfg_data = '0;

	logic [31:0] mdl_period = SAMPLE_PERIOD_RST;
	logic [15:0] mdl_bend = PITCH_BEND_RST;
	logic [6:0]  mdl_level = '0;
	logic [29:0] mdl_freq = '0;
	logic [31:0] mdl_phase = '0;
	int          mdl_ticks = 0;

	longint pitch_top [12] = '{
		64'd435478539, 64'd461373440, 64'd488808132, 64'd517874176,
		64'd548668578, 64'd581294109, 64'd615859655, 64'd652480576,
		64'd691279090, 64'd732384684, 64'd775934544, 64'd822074013
	};
	longint sine_taylor [6] = '{
		64'sd1686629713, -64'sd693598668, 64'sd85569306,
		-64'sd5026995, 64'sd172272, -64'sd3864
	};

	voice_out_t pending_samples [$];
	int send_idle = 9;
	int recv_idle = 51;
	int n_accepted = 0;
	int n_notes = 0;
	int n_results = 0;
	int n_sounding = 0;
	int n_errors = 0;
	int n_settings = 1;

	dir_row_t dir_tab [25] = '{
		'{'{REQ_TICK, 7'd0, 7'd0, 16'd0}, 1'b1, '{16'sd0, 1'b0}},
		'{'{REQ_TICK, 7'd0, 7'd0, 16'd0}, 1'b1, '{16'sd0, 1'b1}},
		'{'{REQ_NOTE_ON, 7'd69, 7'd127, 16'd0}, 1'b0, '0},
		'{'{REQ_TICK, 7'd0, 7'd0, 16'd0}, 1'b1, '{16'sd0, 1'b0}},
		'{'{REQ_TICK, 7'd0, 7'd0, 16'd0}, 1'b0, '0},
		'{'{REQ_TICK, 7'd0, 7'd0, 16'd0}, 1'b0, '0},
		'{'{REQ_TICK, 7'd0, 7'd0, 16'd0}, 1'b0, '0},
		'{'{REQ_NOTE_ON, 7'd127, 7'd127, 16'd3}, 1'b0, '0},
		'{'{REQ_TICK, 7'd0, 7'd0, 16'd0}, 1'b1, '{16'sd0, 1'b0}},
		'{'{REQ_TICK, 7'd0, 7'd0, 16'd0}, 1'b1, '{16'sd0, 1'b0}},
		'{'{REQ_TICK, 7'd0, 7'd0, 16'd0}, 1'b1, '{16'sd0, 1'b0}},
		'{'{REQ_TICK, 7'd0, 7'd0, 16'd0}, 1'b1, '{16'sd0, 1'b0}},
		'{'{REQ_TICK, 7'd0, 7'd0, 16'd0}, 1'b0, '0},
		'{'{REQ_TICK, 7'd0, 7'd0, 16'd0}, 1'b0, '0},
		'{'{REQ_NOTE_ON, 7'd0, 7'd1, 16'd65535}, 1'b0, '0},
		'{'{REQ_TICK, 7'd0, 7'd0, 16'd0}, 1'b1, '{16'sd0, 1'b0}},
		'{'{REQ_TICK, 7'd0, 7'd0, 16'd0}, 1'b1, '{16'sd0, 1'b0}},
		'{'{REQ_NOTE_ON, 7'd0, 7'd0, 16'd0}, 1'b0, '0},
		'{'{REQ_TICK, 7'd0, 7'd0, 16'd0}, 1'b1, '{16'sd0, 1'b0}},
		'{'{REQ_TICK, 7'd0, 7'd0, 16'd0}, 1'b1, '{16'sd0, 1'b1}},
		'{'{REQ_NOTE_ON, 7'd60, 7'd64, 16'd1}, 1'b0, '0},
		'{'{REQ_TICK, 7'd0, 7'd0, 16'd0}, 1'b1, '{16'sd0, 1'b0}},
		'{'{REQ_TICK, 7'd0, 7'd0, 16'd0}, 1'b1, '{16'sd0, 1'b0}},
		'{'{REQ_TICK, 7'd0, 7'd0, 16'd0}, 1'b0, '0},
		'{'{REQ_TICK, 7'd127, 7'd127, 16'hFFFF}, 1'b0, '0}
	};

	note_phase_accumulator_sine_voice u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	function automatic longint mul_trunc30(input longint a, input longint unsigned b);
		longint unsigned m;
		longint unsigned r;
		m = (a < 0) ? -a : a;
		r = (m * b) >> 30;
		return (a < 0) ? -longint'(r) : longint'(r);
	endfunction

	function automatic logic [29:0] note_pitch(input logic [6:0] n);
		int unsigned cls;
		int unsigned sh;
		longint unsigned v;
		cls = (n + 4) % 12;
		sh = 10 - (n + 4) / 12;
		v = pitch_top[cls];
		if (sh > 0) begin
			v = (v + (64'd1 << (sh - 1))) >> sh;
		end
		return v[29:0];
	endfunction

	function automatic longint sine_q30(input logic [9:0] idx);
		longint unsigned t;
		longint unsigned t2;
		longint acc;
		t = longint'(idx[7:0]) << 22;
		if (idx[8]) begin
			t = 64'd1073741824 - t;
		end
		t2 = (t * t) >> 30;
		acc = sine_taylor[5];
		for (int k = 4; k >= 0; k--) begin
			acc = sine_taylor[k] + mul_trunc30(acc, t2);
		end
		acc = mul_trunc30(acc, t);
		if (acc < 0) begin
			acc = 0;
		end
		if (acc > 64'sd1073741824) begin
			acc = 64'sd1073741824;
		end
		return idx[9] ? -acc : acc;
	endfunction

	// Advances the voice by one request; returns 1 when the request yields a sample.
	function automatic logic voice_advance(input voice_req_t r, output voice_out_t y);
		logic [127:0] prod;
		longint s;
		longint unsigned mag;
		y = '0;
		if (r.kind == REQ_NOTE_ON) begin
			mdl_level = r.level;
			mdl_freq = note_pitch(r.note);
			mdl_phase = '0;
			mdl_ticks = -int'(r.delay);
			return 1'b0;
		end
		if (mdl_ticks < 2) begin
			mdl_ticks++;
		end
		if (mdl_ticks <= 1) begin
			return 1'b1;
		end
		prod = 128'(mdl_freq) * 128'(mdl_bend) * 128'(mdl_period);
		mdl_phase = mdl_phase + prod[61:30];
		s = sine_q30(mdl_phase[31:22]);
		mag = (s < 0) ? -s : s;
		mag = (mag * mdl_level * 64'd32767 + 64'd127 * 64'd1073741824)
			/ (64'd254 * 64'd1073741824);
		y.sample = (s < 0) ? -16'(mag) : 16'(mag);
		y.sounding = 1'b1;
		return 1'b1;
	endfunction

	function automatic voice_req_t rand_note();
		voice_req_t r;
		int pick;
		r.kind = REQ_NOTE_ON;
		r.note = 7'($urandom_range(0, 127));
		r.level = 7'($urandom_range(0, 127));
		pick = $urandom_range(0, 99);
		if (pick < 85) begin
			r.delay = 16'($urandom_range(0, 3));
		end else if (pick < 95) begin
			r.delay = 16'($urandom_range(4, 40));
		end else begin
			r.delay = 16'($urandom);
		end
		return r;
	endfunction

	function automatic voice_req_t stray_tick();
		voice_req_t r;
		r = 31'($urandom);
		r.kind = REQ_TICK;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		n_errors++;
		if (n_errors <= PRINT_MAX) begin
			$display("%0t: %s mismatch on result %0d: got %0d, expected %0d",
				$time, what, n_results, got, want);
		end
	endtask

	task automatic send_req(input voice_req_t r, input logic typed, input voice_out_t want);
		voice_out_t y;
		s_tvalid <= 1'b1;
		s_tdata <= {2'b00, r.delay, r.level, r.note};
		s_tuser <= r.kind;
		do @(posedge clk); while (!s_tready);
		if (voice_advance(r, y)) begin
			pending_samples.push_back(typed ? want : y);
		end
		n_accepted++;
		if (r.kind == REQ_NOTE_ON) begin
			n_notes++;
		end
		if (n_accepted == N_ITEMS / 3) begin
			send_idle = 51;
			recv_idle = 9;
		end else if (n_accepted == 2 * N_ITEMS / 3) begin
			send_idle = 0;
			recv_idle = 0;
		end
		if ($urandom_range(0, 99) < send_idle) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	task automatic drain_voice(input logic settle);
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_samples.size() != 0);
		if (settle) begin
			repeat (SETTLE) @(posedge clk);
		end
	endtask

	task automatic set_voice_regs(input logic [31:0] period, input logic [31:0] bend_word);
		cfg_valid <= 1'b1;
		cfg_index <= REG_SAMPLE_PERIOD;
		cfg_data <= period;
		do @(posedge clk); while (!cfg_ready);
		mdl_period = period;
		cfg_index <= REG_PITCH_BEND;
		cfg_data <= bend_word;
		do @(posedge clk); while (!cfg_ready);
		mdl_bend = bend_word[15:0];
		cfg_valid <= 1'b0;
		n_settings++;
	endtask

	always @(posedge clk) begin
		voice_out_t got;
		voice_out_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.sample = m_tdata[15:0];
				got.sounding = m_tuser;
				n_results++;
				if (m_tuser) begin
					n_sounding++;
				end
				if (pending_samples.size() == 0) begin
					report_mismatch("unpredicted result, sample", int'(got.sample), 0);
				end else begin
					want = pending_samples.pop_front();
					if (got.sample !== want.sample) begin
						report_mismatch("sample", int'(got.sample), int'(want.sample));
					end
					if (got.sounding !== want.sounding) begin
						report_mismatch("sounding", int'(got.sounding), int'(want.sounding));
					end
				end
			end
			m_tready <= ($urandom_range(0, 99) >= recv_idle);
		end
	end

	initial begin
		int target;
		int pick;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_tab[i]) begin
			send_req(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].want);
		end
		for (int ph = 0; ph < N_PHASES; ph++) begin
			drain_voice(1'b1);
			case (ph)
				0: set_voice_regs($urandom, $urandom);
				1: set_voice_regs(32'd1, {16'($urandom), 16'hFFFF});
				2: set_voice_regs(32'hFFFF_FFFF, {16'($urandom), 16'h0000});
				3: set_voice_regs(32'hFFFF_FFFF, 32'h0000_FFFF);
				4: set_voice_regs(32'd0, $urandom);
				default: set_voice_regs($urandom_range(44739, 97391), $urandom_range(8192, 32767));
			endcase
			target = n_accepted + (N_ITEMS - n_accepted) / (N_PHASES - ph);
			while (n_accepted < target) begin
				pick = $urandom_range(0, 99);
				if (pick < 8) begin
					send_req(stray_tick(), 1'b0, '0);
				end else if (pick < 12) begin
					send_req(rand_note(), 1'b0, '0);
				end else begin
					send_req(rand_note(), 1'b0, '0);
					repeat ($urandom_range(1, 24)) send_req(stray_tick(), 1'b0, '0);
				end
				if ($urandom_range(0, 99) < 2) begin
					drain_voice(1'b0);
				end
			end
		end
		drain_voice(1'b1);
		$display("Checked %0d results (%0d sounding) from %0d transactions, %0d of them note-ons.",
			n_results, n_sounding, n_accepted, n_notes);
		$display("Covered %0d register settings, including zero and full-scale period and bend.",
			n_settings);
		if (n_errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#10ms;
		$display("== FAIL ==");
		$finish;
	end

endmodule
